// ===== design/ow_pkg.sv =====
package ow_pkg;

	localparam int COUNT_BITS_DEF = 11;

	localparam int CFG_IDX_BITS = 4;
	localparam int CFG_DATA_BITS = 10;

	// command / operation codes
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_RESET = 3'd1;
	localparam logic [2:0] OP_WBYTE = 3'd2;
	localparam logic [2:0] OP_RBYTE = 3'd3;
	localparam logic [2:0] OP_WBIT  = 3'd4;
	localparam logic [2:0] OP_RBIT  = 3'd5;

	// timing register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_RESET_LOW     = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRESENCE_WAIT = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RESET_TAIL    = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ONE_LOW       = 4'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ONE_RELEASE   = 4'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_LOW      = 4'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_READ_LOW      = 4'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_READ_TAIL     = 4'd7;

	localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
	localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd80;
	localparam logic [9:0] RESET_TAIL_DEF    = 10'd410;
	localparam logic [3:0] ONE_LOW_DEF       = 4'd1;
	localparam logic [6:0] ONE_RELEASE_DEF   = 7'd58;
	localparam logic [6:0] ZERO_LOW_DEF      = 7'd60;
	localparam logic [3:0] READ_LOW_DEF      = 4'd2;
	localparam logic [6:0] READ_TAIL_DEF     = 7'd60;

	typedef struct packed {
		logic [9:0] reset_low;
		logic [7:0] presence_wait;
		logic [9:0] reset_tail;
		logic [3:0] one_low;
		logic [6:0] one_release;
		logic [6:0] zero_low;
		logic [3:0] read_low;
		logic [6:0] read_tail;
	} cfg_t;

endpackage

// ===== design/one_wire_bus_master.sv =====
// 1-Wire bus master, one input transaction per microsecond tick.
// The result of a tick is registered and valid in the cycle after the tick is accepted.
// Throughput: one tick per cycle while out_ready does not stall the result; the phase counter and the sequencer
// update in a single pass from registered state.
// Reset: sequencer idle, presence flag set, timing registers at their defaults,
// no result pending.
module one_wire_bus_master
	import ow_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               command,
	input  logic [7:0]               data_byte,
	input  logic                     line_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     drive_low,
	output logic                     busy_res,
	output logic                     done_res,
	output logic [7:0]               read_data,
	output logic                     no_presence,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_RLOW   = 4'd1;
	localparam logic [3:0] PH_RWAIT  = 4'd2;
	localparam logic [3:0] PH_RSAMP  = 4'd3;
	localparam logic [3:0] PH_RTAIL  = 4'd4;
	localparam logic [3:0] PH_WLOW   = 4'd5;
	localparam logic [3:0] PH_WREL   = 4'd6;
	localparam logic [3:0] PH_RDLOW  = 4'd7;
	localparam logic [3:0] PH_RDSAMP = 4'd8;
	localparam logic [3:0] PH_RDTAIL = 4'd9;
	localparam logic [3:0] PH_GAP    = 4'd10;
	localparam logic [3:0] PH_END    = 4'd15;

	cfg_t cfg;

	ow_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	logic [3:0]            phase_q;
	logic [COUNT_BITS-1:0] tick_q;
	logic [2:0]            bit_q;
	logic [7:0]            shift_q;
	logic [2:0]            op_q;
	logic                  pres_q;

	logic                  out_valid_q;
	logic                  drive_q, busy_q, done_q, np_q;
	logic [7:0]            rd_q;

	logic [3:0]            ph, nxt, after_ph;
	logic [COUNT_BITS-1:0] tk;
	logic [2:0]            bi, op;
	logic [7:0]            sh, rd;
	logic                  pr, act, drv, dn, np, wr_op, byte_op;
	logic [9:0]            len;

	function automatic logic [9:0] at_least_one(input logic [6:0] v);
		return (v == 7'd0) ? 10'd1 : {3'd0, v};
	endfunction

	always_comb begin
		ph  = phase_q;
		op  = op_q;
		bi  = bit_q;
		sh  = shift_q;
		tk  = tick_q;
		pr  = pres_q;
		act = 1'b1;
		drv = 1'b0;
		dn  = 1'b0;
		rd  = 8'd0;
		np  = 1'b0;
		nxt = PH_END;
		len = 10'd1;

		if (phase_q == PH_IDLE) begin
			if (command >= OP_RESET && command <= OP_RBIT) begin
				op = command;
				bi = 3'd0;
				tk = '0;
				sh = (command == OP_WBYTE) ? data_byte :
				     (command == OP_WBIT)  ? {7'd0, data_byte[0]} : 8'd0;
				case (command)
					OP_RESET: begin
						// a zero-length reset low or presence wait is skipped up front
						if (cfg.reset_low != 10'd0)          ph = PH_RLOW;
						else if (cfg.presence_wait != 8'd0)  ph = PH_RWAIT;
						else                                 ph = PH_RSAMP;
					end
					OP_WBYTE, OP_WBIT: ph = PH_WLOW;
					default:           ph = PH_RDLOW;
				endcase
			end else begin
				act = 1'b0;
			end
		end

		wr_op    = (op == OP_WBYTE) || (op == OP_WBIT);
		byte_op  = (op == OP_WBYTE) || (op == OP_RBYTE);
		after_ph = byte_op ? PH_GAP : PH_END;

		if (act) begin
			drv = (ph == PH_RLOW) || (ph == PH_WLOW) || (ph == PH_RDLOW);
			if (ph == PH_RSAMP)  pr = line_in;
			if (ph == PH_RDSAMP) sh = {line_in, sh[7:1]};

			case (ph)
				PH_RLOW:   len = cfg.reset_low;
				PH_RWAIT:  len = {2'd0, cfg.presence_wait};
				PH_RTAIL:  len = cfg.reset_tail;
				PH_WLOW:   len = sh[0] ? at_least_one({3'd0, cfg.one_low})
				                       : at_least_one(cfg.zero_low);
				PH_WREL:   len = {3'd0, cfg.one_release};
				PH_RDLOW:  len = at_least_one({3'd0, cfg.read_low});
				PH_RDTAIL: len = {3'd0, cfg.read_tail};
				default:   len = 10'd1;
			endcase

			tk = tk + 1'b1;
			if (tk >= COUNT_BITS'(len)) begin
				tk = '0;
				case (ph)
					PH_RLOW:   nxt = (cfg.presence_wait != 8'd0) ? PH_RWAIT : PH_RSAMP;
					PH_RWAIT:  nxt = PH_RSAMP;
					PH_RSAMP:  nxt = (cfg.reset_tail != 10'd0) ? PH_RTAIL : PH_END;
					PH_WLOW: begin
						if (sh[0] && cfg.one_release != 7'd0) nxt = PH_WREL;
						else                                  nxt = after_ph;
					end
					PH_WREL:   nxt = after_ph;
					PH_RDLOW:  nxt = PH_RDSAMP;
					PH_RDSAMP: nxt = (cfg.read_tail != 7'd0) ? PH_RDTAIL : after_ph;
					PH_RDTAIL: nxt = after_ph;
					PH_GAP: begin
						if (bi == 3'd7) begin
							nxt = PH_END;
						end else begin
							bi = bi + 3'd1;
							if (wr_op) begin
								sh  = {1'b0, sh[7:1]};
								nxt = PH_WLOW;
							end else begin
								nxt = PH_RDLOW;
							end
						end
					end
					default:   nxt = PH_END;
				endcase

				if (nxt == PH_END) begin
					dn = 1'b1;
					if (op == OP_RESET) np = pr;
					if (op == OP_RBYTE || op == OP_RBIT) rd = sh;
					ph = PH_IDLE;
					op = OP_NONE;
				end else begin
					ph = nxt;
				end
			end
		end
	end

	assign in_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			op_q    <= OP_NONE;
			pres_q  <= 1'b1;
		end else if (in_valid && in_ready) begin
			phase_q <= ph;
			tick_q  <= tk;
			bit_q   <= bi;
			shift_q <= sh;
			op_q    <= op;
			pres_q  <= pr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			drive_q <= drv;
			busy_q  <= act;
			done_q  <= dn;
			rd_q    <= rd;
			np_q    <= np;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_low   = drive_q;
	assign busy_res    = busy_q;
	assign done_res    = done_q;
	assign read_data   = rd_q;
	assign no_presence = np_q;

endmodule

// ===== design/ow_cfg_regs.sv =====
module ow_cfg_regs
	import ow_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [CFG_IDX_BITS-1:0]  wr_index,
	input  logic [CFG_DATA_BITS-1:0] wr_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= RESET_LOW_DEF;
			cfg_q.presence_wait <= PRESENCE_WAIT_DEF;
			cfg_q.reset_tail    <= RESET_TAIL_DEF;
			cfg_q.one_low       <= ONE_LOW_DEF;
			cfg_q.one_release   <= ONE_RELEASE_DEF;
			cfg_q.zero_low      <= ZERO_LOW_DEF;
			cfg_q.read_low      <= READ_LOW_DEF;
			cfg_q.read_tail     <= READ_TAIL_DEF;
		end else if (wr_en) begin
			case (wr_index)
				REG_RESET_LOW:     cfg_q.reset_low     <= wr_data[9:0];
				REG_PRESENCE_WAIT: cfg_q.presence_wait <= wr_data[7:0];
				REG_RESET_TAIL:    cfg_q.reset_tail    <= wr_data[9:0];
				REG_ONE_LOW:       cfg_q.one_low       <= wr_data[3:0];
				REG_ONE_RELEASE:   cfg_q.one_release   <= wr_data[6:0];
				REG_ZERO_LOW:      cfg_q.zero_low      <= wr_data[6:0];
				REG_READ_LOW:      cfg_q.read_low      <= wr_data[3:0];
				REG_READ_TAIL:     cfg_q.read_tail     <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/ow_checker.sv =====
module ow_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       drive_low,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data,
	input logic       no_presence
);

	// a completion or a driven bus only happens inside a command
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (done_res || drive_low) |-> busy_res)
		else $error("done or drive without busy");

	// presence result only on the completing tick
	a_np_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_presence |-> done_res)
		else $error("no_presence outside completion");

	// read data only on the completing tick, never with a presence result
	a_rd_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_data != 8'd0) |-> done_res && !no_presence)
		else $error("read_data outside read completion");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) &&
			$stable(done_res) && $stable(drive_low))
		else $error("result changed while stalled");

endmodule

bind one_wire_bus_master ow_checker u_ow_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import ow_pkg::*;

	// command codes outside the defined set, treated as no command
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	// how line_in is chosen while a command runs
	localparam int LINE_LOW  = 0;
	localparam int LINE_HIGH = 1;
	localparam int LINE_RAND = 2;

	typedef enum logic [3:0] {
		SEQ_IDLE       = 4'd0,
		SEQ_RST_LOW    = 4'd1,
		SEQ_RST_WAIT   = 4'd2,
		SEQ_RST_SAMPLE = 4'd3,
		SEQ_RST_TAIL   = 4'd4,
		SEQ_WR_LOW     = 4'd5,
		SEQ_WR_REL     = 4'd6,
		SEQ_RD_LOW     = 4'd7,
		SEQ_RD_SAMPLE  = 4'd8,
		SEQ_RD_TAIL    = 4'd9,
		SEQ_GAP        = 4'd10,
		SEQ_END        = 4'd15
	} seq_phase_e;

	typedef struct packed {
		logic       drive;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
		logic       nopres;
	} tick_result_t;

	class ow_slot_scoreboard;
		logic [9:0] rst_low_t;
		logic [7:0] pres_wait_t;
		logic [9:0] rst_tail_t;
		logic [3:0] one_low_t;
		logic [6:0] one_rel_t;
		logic [6:0] zero_low_t;
		logic [3:0] rd_low_t;
		logic [6:0] rd_tail_t;

		seq_phase_e  seq;
		logic [10:0] tick_cnt;
		logic [2:0]  bit_idx;
		logic [7:0]  shreg;
		logic [2:0]  op;
		logic        pres_flag;

		tick_result_t expected_ticks[$];
		int errors;

		function new();
			rst_low_t   = RESET_LOW_DEF;
			pres_wait_t = PRESENCE_WAIT_DEF;
			rst_tail_t  = RESET_TAIL_DEF;
			one_low_t   = ONE_LOW_DEF;
			one_rel_t   = ONE_RELEASE_DEF;
			zero_low_t  = ZERO_LOW_DEF;
			rd_low_t    = READ_LOW_DEF;
			rd_tail_t   = READ_TAIL_DEF;
			seq       = SEQ_IDLE;
			tick_cnt  = '0;
			bit_idx   = '0;
			shreg     = '0;
			op        = OP_NONE;
			pres_flag = 1'b1;
			errors    = 0;
		endfunction

		function void write_timing(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			case (idx)
				REG_RESET_LOW:     rst_low_t   = val;
				REG_PRESENCE_WAIT: pres_wait_t = val[7:0];
				REG_RESET_TAIL:    rst_tail_t  = val;
				REG_ONE_LOW:       one_low_t   = val[3:0];
				REG_ONE_RELEASE:   one_rel_t   = val[6:0];
				REG_ZERO_LOW:      zero_low_t  = val[6:0];
				REG_READ_LOW:      rd_low_t    = val[3:0];
				REG_READ_TAIL:     rd_tail_t   = val[6:0];
				default: ;
			endcase
		endfunction

		function bit idle();
			return seq == SEQ_IDLE;
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

		function bit byte_op();
			return op == OP_WBYTE || op == OP_RBYTE;
		endfunction

		// low pulses never shorter than one tick
		function int unsigned at_least_one(int unsigned v);
			return (v == 0) ? 1 : v;
		endfunction

		function int unsigned stretch(seq_phase_e p);
			case (p)
				SEQ_RST_LOW:  return rst_low_t;
				SEQ_RST_WAIT: return pres_wait_t;
				SEQ_RST_TAIL: return rst_tail_t;
				SEQ_WR_LOW:   return shreg[0] ? at_least_one(one_low_t) : at_least_one(zero_low_t);
				SEQ_WR_REL:   return one_rel_t;
				SEQ_RD_LOW:   return at_least_one(rd_low_t);
				SEQ_RD_TAIL:  return rd_tail_t;
				default:      return 1;
			endcase
		endfunction

		// leaving the gap tick advances to the next bit of a byte
		function seq_phase_e next_phase(seq_phase_e p);
			case (p)
				SEQ_RST_LOW:    return SEQ_RST_WAIT;
				SEQ_RST_WAIT:   return SEQ_RST_SAMPLE;
				SEQ_RST_SAMPLE: return SEQ_RST_TAIL;
				SEQ_WR_LOW: begin
					if (shreg[0])
						return SEQ_WR_REL;
					return byte_op() ? SEQ_GAP : SEQ_END;
				end
				SEQ_WR_REL, SEQ_RD_TAIL: return byte_op() ? SEQ_GAP : SEQ_END;
				SEQ_RD_LOW:    return SEQ_RD_SAMPLE;
				SEQ_RD_SAMPLE: return SEQ_RD_TAIL;
				SEQ_GAP: begin
					if (bit_idx >= 3'd7)
						return SEQ_END;
					bit_idx = bit_idx + 3'd1;
					if (op == OP_WBYTE || op == OP_WBIT) begin
						shreg = shreg >> 1;
						return SEQ_WR_LOW;
					end
					return SEQ_RD_LOW;
				end
				default: return SEQ_END;
			endcase
		endfunction

		function seq_phase_e skip_empty(seq_phase_e p);
			seq_phase_e q;
			q = p;
			while (q != SEQ_END && stretch(q) == 0)
				q = next_phase(q);
			return q;
		endfunction

		function void note_tick(logic [2:0] cmd, logic [7:0] data, logic line);
			tick_result_t r;
			seq_phase_e nxt;
			r = '0;
			if (seq == SEQ_IDLE) begin
				if (cmd < OP_RESET || cmd > OP_RBIT) begin
					expected_ticks.push_back(r);
					return;
				end
				op = cmd;
				bit_idx = '0;
				tick_cnt = '0;
				shreg = (cmd == OP_WBYTE) ? data : (cmd == OP_WBIT) ? {7'b0, data[0]} : 8'h00;
				if (cmd == OP_RESET)
					seq = SEQ_RST_LOW;
				else if (cmd == OP_WBYTE || cmd == OP_WBIT)
					seq = SEQ_WR_LOW;
				else
					seq = SEQ_RD_LOW;
				seq = skip_empty(seq);
			end

			r.drive = (seq == SEQ_RST_LOW || seq == SEQ_WR_LOW || seq == SEQ_RD_LOW);
			if (seq == SEQ_RST_SAMPLE)
				pres_flag = line;
			if (seq == SEQ_RD_SAMPLE)
				shreg = {line, shreg[7:1]};

			tick_cnt = tick_cnt + 11'd1;
			if (tick_cnt >= stretch(seq)) begin
				tick_cnt = '0;
				nxt = skip_empty(next_phase(seq));
				if (nxt == SEQ_END) begin
					r.done = 1'b1;
					if (op == OP_RESET)
						r.nopres = pres_flag;
					if (op == OP_RBYTE || op == OP_RBIT)
						r.rdata = shreg;
					seq = SEQ_IDLE;
					op = OP_NONE;
				end else begin
					seq = nxt;
				end
			end
			r.busy = 1'b1;
			expected_ticks.push_back(r);
		endfunction

		function void report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, actual %0h",
					$time, name, exp_v, act_v);
			end
		endfunction

		function void check_tick(logic drive, logic busy, logic done, logic [7:0] rdata,
				logic nopres);
			tick_result_t e;
			if (expected_ticks.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction: expected none, actual %0h %0h %0h %0h %0h",
					$time, drive, busy, done, rdata, nopres);
				return;
			end
			e = expected_ticks.pop_front();
			report_field("drive_low", 8'(e.drive), 8'(drive));
			report_field("busy_res", 8'(e.busy), 8'(busy));
			report_field("done_res", 8'(e.done), 8'(done));
			report_field("read_data", e.rdata, rdata);
			report_field("no_presence", 8'(e.nopres), 8'(nopres));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] command;
	logic [7:0] data_byte;
	logic line_in;
	logic out_valid;
	logic out_ready = 1'b0;
	logic drive_low;
	logic busy_res;
	logic done_res;
	logic [7:0] read_data;
	logic no_presence;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int sent_ticks = 0;

	ow_slot_scoreboard slot_sb;

	one_wire_bus_master dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.data_byte  (data_byte),
		.line_in    (line_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive_low  (drive_low),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data),
		.no_presence(no_presence),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			slot_sb.check_tick(drive_low, busy_res, done_res, read_data, no_presence);
	end

	task automatic set_idling(int mode);
		case (mode)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 65; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 65; end
			default: begin src_idle_pct = 38; snk_stall_pct = 38; end
		endcase
	endtask

	// valid stays high across back-to-back ticks; lowered only for a gap
	task automatic send_tick(logic [2:0] cmd, logic [7:0] data, logic line);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		data_byte <= data;
		line_in   <= line;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		slot_sb.note_tick(cmd, data, line);
		sent_ticks++;
	endtask

	function automatic logic pick_line(int sel);
		if (sel == LINE_RAND)
			return 1'($urandom_range(1));
		return (sel == LINE_HIGH);
	endfunction

	// one command, then ticks with stray commands until the sequencer is idle
	task automatic run_op(logic [2:0] cmd, logic [7:0] data, int line_sel);
		logic [2:0] noise;
		send_tick(cmd, data, pick_line(line_sel));
		while (!slot_sb.idle()) begin
			noise = ($urandom_range(99) < 30) ? 3'($urandom_range(7)) : OP_NONE;
			send_tick(noise, 8'($urandom), pick_line(line_sel));
		end
	endtask

	// random commands until about n_ticks more ticks have been sent
	task automatic random_ops(int n_ticks);
		int stop_at;
		logic [2:0] cmd;
		stop_at = sent_ticks + n_ticks;
		while (sent_ticks < stop_at) begin
			cmd = 3'($urandom_range(7));
			run_op(cmd, 8'($urandom), LINE_RAND);
		end
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (slot_sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		slot_sb.write_timing(idx, val);
	endtask

	// mode 0: short random timings, 1: all ones, 2: all zero
	task automatic program_timing(int mode);
		int reg_width[8];
		logic [CFG_DATA_BITS-1:0] val;
		reg_width = '{10, 8, 10, 4, 7, 7, 4, 7};
		for (int r = 0; r < 8; r++) begin
			if (mode == 1)
				val = '1;
			else if (mode == 2)
				val = '0;
			else
				// junk above the register width must be dropped
				val = CFG_DATA_BITS'(($urandom << reg_width[r]) | $urandom_range(3));
			write_reg(CFG_IDX_BITS'(r), val);
		end
		write_reg(CFG_IDX_BITS'($urandom_range(8, 15)), CFG_DATA_BITS'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		slot_sb = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = OP_NONE;
		data_byte = 8'h00;
		line_in   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_RESET_LOW;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-on timings
		set_idling(0);
		run_op(OP_WBIT, 8'h01, LINE_RAND);

		// each command and its corner cases on short timings
		quiesce();
		program_timing(0);
		run_op(OP_RESET, 8'h00, LINE_LOW);
		run_op(OP_RESET, 8'h00, LINE_HIGH);
		run_op(OP_WBYTE, 8'hA5, LINE_RAND);
		run_op(OP_RBYTE, 8'h00, LINE_RAND);
		run_op(OP_WBIT, 8'hFE, LINE_RAND);
		run_op(OP_RBIT, 8'h00, LINE_LOW);
		run_op(OP_RBIT, 8'h00, LINE_HIGH);
		run_op(CMD_RSVD6, 8'h5A, LINE_RAND);
		run_op(CMD_RSVD7, 8'hC3, LINE_RAND);
		run_op(OP_NONE, 8'h00, LINE_RAND);

		for (int s = 0; s < 4; s++) begin
			quiesce();
			program_timing(0);
			set_idling(s);
			random_ops(40);
		end

		quiesce();
		program_timing(2);
		set_idling(3);
		random_ops(30);

		quiesce();
		repeat (5) @(posedge clk);
		if (slot_sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
